### rtl/imm4x4_pkg.sv
package imm4x4_pkg;

    localparam int WORD_W = 32;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ISSUE,
        ST_DRAIN,
        ST_PUSH
    } state_t;

    // Tag that travels down the multiply-accumulate pipe with each term
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } mac_req_t;

endpackage

### rtl/imm4x4_store.sv
module imm4x4_store import imm4x4_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              clk,
    input  logic              wr_a,
    input  logic              wr_b,
    input  logic [AW-1:0]     wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic [AW-1:0]     rd_addr_a,
    input  logic [AW-1:0]     rd_addr_b,
    output logic [WORD_W-1:0] rd_data_a,
    output logic [WORD_W-1:0] rd_data_b
);

    logic [WORD_W-1:0] mem_a [DEPTH];
    logic [WORD_W-1:0] mem_b [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[wr_addr] <= wr_data;
        end
        if (wr_b)
        begin
            mem_b[wr_addr] <= wr_data;
        end
        rd_data_a <= mem_a[rd_addr_a];
        rd_data_b <= mem_b[rd_addr_b];
    end

endmodule

### rtl/imm4x4_mac.sv
module imm4x4_mac import imm4x4_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  mac_req_t          req,
    input  logic [WORD_W-1:0] a_data,
    input  logic [WORD_W-1:0] b_data,
    output logic [WORD_W-1:0] acc,
    output logic              done
);

    mac_req_t          s1_reg;
    mac_req_t          s2_reg;
    logic [WORD_W-1:0] prod_reg;
    logic [WORD_W-1:0] prod_next;
    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] acc_next;
    logic              done_reg;
    logic              done_next;

    // Low word of the product is the same for signed and unsigned operands
    assign prod_next = a_data * b_data;
    assign acc_next  = (s2_reg.first ? '0 : acc_reg) + prod_reg;
    assign done_next = s2_reg.vld & s2_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= '0;
            s2_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_reg   <= req;
            s2_reg   <= s1_reg;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_reg.vld)
        begin
            prod_reg <= prod_next;
        end
        if (s2_reg.vld)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

### rtl/imm4x4_ctrl.sv
module imm4x4_ctrl import imm4x4_pkg::*; #(
    parameter int DIM = 4,
    parameter int AW  = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          out_free,
    input  logic          mac_done,
    output logic          wr_a,
    output logic          wr_b,
    output logic [AW-1:0] wr_addr,
    output logic [AW-1:0] rd_addr_a,
    output logic [AW-1:0] rd_addr_b,
    output mac_req_t      req,
    output logic          push,
    output logic          push_last
);

    localparam int CELLS = DIM * DIM;
    localparam int LW    = $clog2(2 * CELLS);
    localparam int CW    = $clog2(DIM);

    state_t        state_reg;
    state_t        state_next;
    logic [LW-1:0] cnt_reg;
    logic [LW-1:0] cnt_next;
    logic [CW-1:0] r_reg;
    logic [CW-1:0] r_next;
    logic [CW-1:0] c_reg;
    logic [CW-1:0] c_next;
    logic [CW-1:0] k_reg;
    logic [CW-1:0] k_next;
    logic          accept;
    logic          is_b;
    logic          last_cell;

    assign accept    = in_valid & ~in_stall;
    assign is_b      = cnt_reg >= LW'(CELLS);
    assign last_cell = (r_reg == CW'(DIM - 1)) && (c_reg == CW'(DIM - 1));

    assign wr_a      = accept & ~is_b;
    assign wr_b      = accept & is_b;
    assign wr_addr   = is_b ? AW'(cnt_reg - LW'(CELLS)) : cnt_reg[AW-1:0];
    assign rd_addr_a = AW'(r_reg) * AW'(DIM) + AW'(k_reg);
    assign rd_addr_b = AW'(k_reg) * AW'(DIM) + AW'(c_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            r_reg     <= '0;
            c_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        k_next     = k_reg;
        in_stall   = 1'b1;
        req        = '0;
        push       = 1'b0;
        push_last  = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (cnt_reg == LW'(2 * CELLS - 1))
                    begin
                        cnt_next   = '0;
                        r_next     = '0;
                        c_next     = '0;
                        k_next     = '0;
                        state_next = ST_ISSUE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_ISSUE:
            begin
                req.vld   = 1'b1;
                req.first = (k_reg == '0);
                req.last  = (k_reg == CW'(DIM - 1));
                if (k_reg == CW'(DIM - 1))
                begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (mac_done)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                // hold the sum until the output register can take it
                if (out_free)
                begin
                    push      = 1'b1;
                    push_last = last_cell;
                    if (last_cell)
                    begin
                        r_next     = '0;
                        c_next     = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                        if (c_reg == CW'(DIM - 1))
                        begin
                            c_next = '0;
                            r_next = r_reg + 1'b1;
                        end
                        else
                        begin
                            c_next = c_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

### rtl/int_matrix_multiply_4x4.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+------------------------------
// input    | in_valid, in_stall  | element (A then B, row-major)
// output   | out_valid, out_stall| product, last_out (C, row-major)
//
// Loading accepts one element per cycle, 2*DIM*DIM transfers in all.
// After the last element of B, each element of C takes DIM reads of the two stores,
// then the multiply and accumulate stages.
// Input is stalled from the last B transfer until the final C element is registered.
// rst_n clears the load count and the sequencer; store contents are kept.
// A stalled output holds the sequencer in its push state.
module int_matrix_multiply_4x4 import imm4x4_pkg::*; #(
    parameter int DIM = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] element,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] product,
    output logic        last_out
);

    localparam int CELLS = DIM * DIM;
    localparam int AW    = $clog2(CELLS);

    logic              wr_a;
    logic              wr_b;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr_a;
    logic [AW-1:0]     rd_addr_b;
    logic [WORD_W-1:0] rd_data_a;
    logic [WORD_W-1:0] rd_data_b;
    mac_req_t          req;
    logic [WORD_W-1:0] acc;
    logic              mac_done;
    logic              push;
    logic              push_last;
    logic              out_free;
    logic              out_valid_reg;
    logic              last_reg;
    logic [WORD_W-1:0] product_reg;

    assign out_free = ~out_valid_reg | ~out_stall;

    imm4x4_ctrl #(
        .DIM (DIM),
        .AW  (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_free  (out_free),
        .mac_done  (mac_done),
        .wr_a      (wr_a),
        .wr_b      (wr_b),
        .wr_addr   (wr_addr),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .req       (req),
        .push      (push),
        .push_last (push_last)
    );

    imm4x4_store #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_store (
        .clk       (clk),
        .wr_a      (wr_a),
        .wr_b      (wr_b),
        .wr_addr   (wr_addr),
        .wr_data   (element),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    imm4x4_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .a_data (rd_data_a),
        .b_data (rd_data_b),
        .acc    (acc),
        .done   (mac_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (~out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            product_reg <= acc;
            last_reg    <= push_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign product   = product_reg;
    assign last_out  = last_reg;

endmodule

### rtl/imm4x4_check.sv
module imm4x4_check (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [31:0] element,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] product,
    input logic        last_out
);

    // stalled element holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(element))
        else $error("stalled element changed");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(product) && $stable(last_out))
        else $error("stalled result changed");

    // a result other than the final one only appears while loading is blocked
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_out |-> in_stall)
        else $error("input open while product incomplete");

    // loading reopens exactly when the final element is registered
    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> out_valid && last_out)
        else $error("input reopened without final result");

    // nothing follows the final result until a new pair is loaded
    a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_out |=> !out_valid)
        else $error("result after final element");

endmodule

bind int_matrix_multiply_4x4 imm4x4_check u_check (.*);

### test/tb_int_matrix_multiply_4x4.sv
`timescale 1ns / 1ps

module tb_int_matrix_multiply_4x4 import imm4x4_pkg::*;;

    localparam int DIM = 4;
    localparam int CELLS = DIM * DIM;
    localparam int RANDOM_PAIRS = 7;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              last;
    } c_entry_t;

    // One directed matrix pair: A is a fill or a scaled identity, B a ramp
    typedef struct packed {
        logic [WORD_W-1:0] a_val;
        logic              a_diag;
        logic [WORD_W-1:0] b_val;
        logic [WORD_W-1:0] b_step;
        logic              c_known;
        logic [WORD_W-1:0] c_val;
    } pair_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [WORD_W-1:0] element;
    logic              out_valid;
    logic              out_stall;
    logic [WORD_W-1:0] product;
    logic              last_out;

    logic [WORD_W-1:0] mat_a [CELLS];
    logic [WORD_W-1:0] mat_b [CELLS];
    int unsigned       load_idx;
    c_entry_t          pending_c [$];

    logic [WORD_W-1:0] next_a [CELLS];
    logic [WORD_W-1:0] next_b [CELLS];
    logic              typed_known;
    logic [WORD_W-1:0] typed_c;
    bit                steady;

    pair_row_t   directed_rows [0:4];
    int unsigned error_count;
    int unsigned results_checked;
    int unsigned pairs_loaded;
    int unsigned idle_cycles;

    int_matrix_multiply_4x4 #(.DIM(DIM)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .element   (element),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .product   (product),
        .last_out  (last_out)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Wrapped dot product of row r of A and column c of B
    function automatic logic [WORD_W-1:0] c_entry(input int unsigned r, input int unsigned c);
        logic [WORD_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < DIM; k++)
        begin
            acc = acc + mat_a[r * DIM + k] * mat_b[k * DIM + c];
        end
        return acc;
    endfunction

    // Load one transferred element; the last element of B yields all of C
    task automatic absorb_element(input logic [WORD_W-1:0] v);
        c_entry_t want;
        if (load_idx < CELLS)
            mat_a[load_idx] = v;
        else
            mat_b[load_idx - CELLS] = v;
        load_idx++;
        if (load_idx == 2 * CELLS)
        begin
            load_idx = 0;
            pairs_loaded++;
            for (int idx = 0; idx < CELLS; idx++)
            begin
                want.value = typed_known ? typed_c : c_entry(idx / DIM, idx % DIM);
                want.last = (idx == CELLS - 1);
                pending_c.push_back(want);
            end
        end
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [WORD_W-1:0] random_element(input int unsigned flavour);
        logic [WORD_W-1:0] v;
        case (flavour)
            0: v = $urandom;
            1:
            begin
                v = $urandom_range(0, 15);
                v = v - 8;
            end
            default:
            begin
                case ($urandom_range(0, 5))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    3: v = 32'h0000_0001;
                    4: v = 32'hFFFF_FFFF;
                    default: v = $urandom;
                endcase
            end
        endcase
        return v;
    endfunction

    // Offer one element, hold it until transferred, then idle for a random gap, possibly none
    task automatic send_element(input logic [WORD_W-1:0] v);
        int unsigned gap;
        in_valid <= 1'b1;
        element <= v;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        absorb_element(v);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_pair();
        for (int i = 0; i < CELLS; i++)
            send_element(next_a[i]);
        for (int i = 0; i < CELLS; i++)
            send_element(next_b[i]);
    endtask

    task automatic drain_products();
        in_valid <= 1'b0;
        while (pending_c.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : product_check
        c_entry_t want;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (pending_c.size() == 0)
            begin
                report_mismatch("product with nothing expected", product, '0);
            end
            else
            begin
                want = pending_c.pop_front();
                if (product !== want.value)
                    report_mismatch("product", product, want.value);
                if (last_out !== want.last)
                    report_mismatch("last_out", WORD_W'(last_out), WORD_W'(want.last));
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == STALL_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver back-pressure: short and long stalls, with quiet stretches
    initial
    begin : stall_driver
        int unsigned r;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            r = $urandom_range(0, 9);
            if (r < 2)
            begin
                repeat ($urandom_range(30, 120)) @(posedge clk);
            end
            else
            begin
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_stall <= 1'b1;
                repeat (r < 8 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int unsigned flavour;
        rst_n = 1'b0;
        in_valid = 1'b0;
        element = '0;
        load_idx = 0;
        error_count = 0;
        results_checked = 0;
        pairs_loaded = 0;
        idle_cycles = 0;
        typed_known = 1'b0;
        typed_c = '0;
        steady = 1'b0;

        // identity times a ramp across the signed wrap, wrapped fills, then a scaled identity times a ramp
        directed_rows[0] = '{32'h0000_0001, 1'b1, 32'h7FFF_FFF8, 32'h0000_0001, 1'b0, 32'h0};
        directed_rows[1] = '{32'h7FFF_FFFF, 1'b0, 32'h7FFF_FFFF, 32'h0, 1'b1, 32'h0000_0004};
        directed_rows[2] = '{32'h8000_0000, 1'b0, 32'h8000_0000, 32'h0, 1'b1, 32'h0000_0000};
        directed_rows[3] = '{32'hFFFF_FFFF, 1'b0, 32'h0000_0001, 32'h0, 1'b1, 32'hFFFF_FFFC};
        directed_rows[4] = '{32'h8000_0000, 1'b1, 32'h0000_0000, 32'h1111_1111, 1'b0, 32'h0};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int row = 0; row < 5; row++)
        begin
            for (int i = 0; i < CELLS; i++)
            begin
                if (directed_rows[row].a_diag)
                    next_a[i] = (i % (DIM + 1) == 0) ? directed_rows[row].a_val : '0;
                else
                    next_a[i] = directed_rows[row].a_val;
                next_b[i] = directed_rows[row].b_val + i * directed_rows[row].b_step;
            end
            typed_known = directed_rows[row].c_known;
            typed_c = directed_rows[row].c_val;
            steady = (row == 2);
            send_pair();
        end

        // hold off until every product is back before the random part
        drain_products();
        typed_known = 1'b0;

        for (int p = 0; p < RANDOM_PAIRS; p++)
        begin
            flavour = $urandom_range(0, 3);
            for (int i = 0; i < CELLS; i++)
            begin
                next_a[i] = random_element(flavour);
                next_b[i] = random_element(flavour == 3 ? $urandom_range(0, 2) : flavour);
            end
            steady = ($urandom_range(0, 3) == 0);
            send_pair();
            if (p == RANDOM_PAIRS / 2)
                drain_products();
        end

        drain_products();
        repeat (4 * (DIM + 4)) @(posedge clk);

        $display("Multiplied %0d matrix pairs (directed fills, identities, random data)",
                 pairs_loaded);
        $display("Checked %0d product elements under random gaps and stalls", results_checked);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
